// ----- sv/u8sd_pkg.sv -----
`default_nettype none

package u8sd_pkg;

	localparam int BYTE_W      = 8;
	localparam int AVAIL_W     = 3;
	localparam int CP_W        = 31;
	localparam int LEN_W       = 3;
	localparam int CONT_BITS   = 6;
	localparam int LEAD_BITS   = 7;
	localparam int ONES_W      = 4;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		ST_CHAR       = 2'd0,
		ST_END        = 2'd1,
		ST_INVALID    = 2'd2,
		ST_INCOMPLETE = 2'd3
	} status_t;

	// Class of a byte as seen without knowing whether a sequence is open.
	typedef enum logic [1:0] {
		K_ASCII = 2'd0,
		K_NUL   = 2'd1,
		K_LEAD  = 2'd2,
		K_BAD   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0]    data_byte;
		kind_t                kind;
		logic                 avail_zero;
		logic                 lead_short;
		logic [LEN_W-1:0]     lead_len;
		logic [LEAD_BITS-1:0] lead_bits;
	} fe_word_t;

endpackage

`default_nettype wire

// ----- sv/u8sd_in_if.sv -----
`default_nettype none

interface u8sd_in_if;
	import u8sd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [BYTE_W-1:0]    data_byte;
	logic [AVAIL_W-1:0]   bytes_available;

	modport source (output valid, output data_byte, output bytes_available, input ready);
	modport sink   (input valid, input data_byte, input bytes_available, output ready);
endinterface

`default_nettype wire

// ----- sv/u8sd_out_if.sv -----
`default_nettype none

interface u8sd_out_if;
	import u8sd_pkg::*;

	logic              valid;
	logic              ready;
	logic [CP_W-1:0]   code_point;
	status_t           status;
	logic [LEN_W-1:0]  sequence_length;

	modport source (output valid, output code_point, output status, output sequence_length,
		input ready);
	modport sink   (input valid, input code_point, input status, input sequence_length,
		output ready);
endinterface

`default_nettype wire

// ----- sv/u8sd_front.sv -----
`default_nettype none

module u8sd_front #(
	parameter int MAX_SEQUENCE_BYTES = 6
) (
	u8sd_in_if.sink             byte_in,
	input  logic                queue_full,
	output logic                word_valid,
	output u8sd_pkg::fe_word_t  word
);
	import u8sd_pkg::*;

	localparam logic [ONES_W-1:0] MAX_ONES = ONES_W'(MAX_SEQUENCE_BYTES);

	logic [ONES_W-1:0] ones;
	logic              run;

	assign byte_in.ready = !queue_full;
	assign word_valid    = byte_in.valid;

	// Count the leading ones of the byte, which give the length of a lead byte.
	always_comb begin
		ones = '0;
		run  = 1'b1;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			if (run && byte_in.data_byte[i]) begin
				ones = ones + ONES_W'(1);
			end else begin
				run = 1'b0;
			end
		end
	end

	always_comb begin
		word.data_byte  = byte_in.data_byte;
		word.avail_zero = (byte_in.bytes_available == '0);
		word.lead_short = (ones > {1'b0, byte_in.bytes_available});
		word.lead_len   = ones[LEN_W-1:0];
		word.lead_bits  = byte_in.data_byte[LEAD_BITS-1:0] & (7'h7f >> ones);
		if (!byte_in.data_byte[BYTE_W-1]) begin
			word.kind = (byte_in.data_byte == '0) ? K_NUL : K_ASCII;
		end else if (ones >= ONES_W'(2) && ones <= MAX_ONES) begin
			word.kind = K_LEAD;
		end else begin
			word.kind = K_BAD;
		end
	end
endmodule

`default_nettype wire

// ----- sv/u8sd_queue.sv -----
`default_nettype none

module u8sd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  u8sd_pkg::fe_word_t  push_word,
	output logic                full,
	input  logic                pop,
	output logic                pop_valid,
	output u8sd_pkg::fe_word_t  pop_word
);
	import u8sd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	fe_word_t           slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign push      = push_valid && !full;
	assign pop_word  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end
endmodule

`default_nettype wire

// ----- sv/u8sd_back.sv -----
`default_nettype none

module u8sd_back #(
	parameter int MAX_SEQUENCE_BYTES = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  u8sd_pkg::fe_word_t  q_word,
	output logic                pop,
	u8sd_out_if.source          char_out
);
	import u8sd_pkg::*;

	logic [LEN_W-1:0]  bytes_pending_q;
	logic [LEN_W-1:0]  sequence_total_q;
	logic [CP_W-1:0]   partial_value_q;

	logic              out_valid_q;
	logic [CP_W-1:0]   code_point_q;
	status_t           status_q;
	logic [LEN_W-1:0]  length_q;

	logic              emit;
	logic [CP_W-1:0]   emit_cp;
	status_t           emit_status;
	logic [LEN_W-1:0]  emit_len;
	logic [LEN_W-1:0]  pending_d;
	logic [LEN_W-1:0]  total_d;
	logic [CP_W-1:0]   partial_d;
	logic [CP_W-1:0]   shifted;
	logic              is_cont;

	assign pop = q_valid && (!out_valid_q || char_out.ready);

	assign char_out.valid           = out_valid_q;
	assign char_out.code_point      = code_point_q;
	assign char_out.status          = status_q;
	assign char_out.sequence_length = length_q;

	assign is_cont = (q_word.data_byte[BYTE_W-1 -: 2] == 2'b10);
	assign shifted = {partial_value_q[CP_W-CONT_BITS-1:0], q_word.data_byte[CONT_BITS-1:0]};

	always_comb begin
		emit        = 1'b0;
		emit_cp     = '0;
		emit_status = ST_CHAR;
		emit_len    = '0;
		pending_d   = bytes_pending_q;
		total_d     = sequence_total_q;
		partial_d   = partial_value_q;
		if (bytes_pending_q != '0) begin
			if (!is_cont) begin
				// A bad continuation byte is consumed and counted in the length.
				emit        = 1'b1;
				emit_status = ST_INVALID;
				emit_len    = sequence_total_q - bytes_pending_q + LEN_W'(1);
				pending_d   = '0;
				total_d     = '0;
				partial_d   = '0;
			end else if (bytes_pending_q == LEN_W'(1)) begin
				emit      = 1'b1;
				emit_cp   = shifted;
				emit_len  = sequence_total_q;
				pending_d = '0;
				total_d   = '0;
				partial_d = '0;
			end else begin
				partial_d = shifted;
				pending_d = bytes_pending_q - LEN_W'(1);
			end
		end else if (q_word.avail_zero) begin
			emit        = 1'b1;
			emit_status = ST_INCOMPLETE;
		end else begin
			case (q_word.kind)
				K_ASCII: begin
					emit     = 1'b1;
					emit_cp  = CP_W'(q_word.data_byte);
					emit_len = LEN_W'(1);
				end
				K_NUL: begin
					emit        = 1'b1;
					emit_status = ST_END;
					emit_len    = LEN_W'(1);
				end
				K_LEAD: begin
					if (q_word.lead_short) begin
						emit        = 1'b1;
						emit_status = ST_INCOMPLETE;
					end else begin
						partial_d = CP_W'(q_word.lead_bits);
						pending_d = q_word.lead_len - LEN_W'(1);
						total_d   = q_word.lead_len;
					end
				end
				default: begin
					emit        = 1'b1;
					emit_status = ST_INVALID;
					emit_len    = LEN_W'(1);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_pending_q  <= '0;
			sequence_total_q <= '0;
			partial_value_q  <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (pop) begin
				bytes_pending_q  <= pending_d;
				sequence_total_q <= total_d;
				partial_value_q  <= partial_d;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (char_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			code_point_q <= emit_cp;
			status_q     <= emit_status;
			length_q     <= emit_len;
		end
	end

`ifndef SYNTHESIS
	a_pending_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_pending_q != '0 |-> bytes_pending_q < sequence_total_q)
		else $error("pending count not below sequence length");

	a_pending_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_pending_q <= LEN_W'(MAX_SEQUENCE_BYTES - 1))
		else $error("pending count above the longest sequence");

	a_cp_zero_unless_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_CHAR |-> code_point_q == '0)
		else $error("non-character result carries a code point");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from an empty queue");
`endif
endmodule

`default_nettype wire

// ----- sv/utf8_stream_decoder.sv -----
`default_nettype none

// Byte-serial UTF-8 decoder for the original form with sequences of up to six bytes.
// Each input word carries one stream byte and the number of buffer bytes left from it
// on; each result word carries a 31-bit code point, a status (character, end of string,
// invalid, incomplete) and the number of bytes it consumed. Lead bytes that open a
// sequence and middle continuation bytes give no result. The front classifies each
// byte combinationally and pushes it into a two-word queue; the back holds the open
// sequence and an output register. A byte is taken every cycle in steady flow. The
// byte that completes a result is written into the queue and then, when the back
// takes it, into the output register that holds the result word. Results leave at
// up to one per cycle. In steady flow the queue holds one word, so a stall on the
// output side fills the spare slot and then holds the input off while the queue is
// full; the input stays stopped until the output accepts again.
module utf8_stream_decoder #(
	parameter int MAX_SEQUENCE_BYTES = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	u8sd_in_if.sink     byte_in,
	u8sd_out_if.source  char_out
);
	import u8sd_pkg::*;

	fe_word_t  fe_word;
	logic      fe_valid;
	logic      queue_full;
	fe_word_t  q_word;
	logic      q_valid;
	logic      q_pop;

	u8sd_front #(
		.MAX_SEQUENCE_BYTES(MAX_SEQUENCE_BYTES)
	) u_front (
		.byte_in    (byte_in),
		.queue_full (queue_full),
		.word_valid (fe_valid),
		.word       (fe_word)
	);

	u8sd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_word  (fe_word),
		.full       (queue_full),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_word   (q_word)
	);

	u8sd_back #(
		.MAX_SEQUENCE_BYTES(MAX_SEQUENCE_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_word   (q_word),
		.pop      (q_pop),
		.char_out (char_out)
	);
endmodule

`default_nettype wire
